@@ src/tscc_pkg.sv @@
// shared types, constants and helpers for the transport stream continuity checker
// no dependencies; imported by ts_continuity_checker
package tscc_pkg;

    localparam int STREAM_COUNT = 2;
    localparam int SEL_W        = 1;
    localparam int PID_W        = 13;
    localparam int CC_W         = 4;
    localparam int CNT_W        = 32;
    localparam int OUT_W        = 32;
    localparam int IDX_W        = SEL_W + PID_W;
    localparam int TABLE_DEPTH  = 1 << IDX_W;

    localparam int IN_BITS   = PID_W + CC_W + 5;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + 7 * OUT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CC_UNCHECKED = 2'd0,
        CC_IN_ORDER  = 2'd1,
        CC_DUPLICATE = 2'd2,
        CC_ERROR     = 2'd3
    } cc_status_t;

    // one entry per stream and identifier
    typedef struct packed {
        logic [CC_W-1:0]  last_cc;
        logic             seen;
        logic [CNT_W-1:0] pid_count;
    } pid_entry_t;

    typedef struct packed {
        logic [PID_W-1:0] packet_id;
        logic [CC_W-1:0]  cont_count;
        logic             tei_flag;
        logic             null_flag;
        logic             pcr_flag;
        logic             disc_flag;
        logic             payload_flag;
    } hdr_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        return (en && (v != {CNT_W{1'b1}})) ? v + 1'b1 : v;
    endfunction

endpackage

@@ src/ts_continuity_checker.sv @@
// transport stream continuity checker top level
// per-identifier state lives in one synchronous ram; depends on tscc_pkg
//
// usage:
//   s_ channel takes one parsed packet header per request: tuser carries the
//   stream select, tdata the identifier, continuity counter and header flags.
//   m_ channel returns one result per request: the check status, the stream's
//   saturating totals and the packet count for the stream and identifier.
//   a request's header and its ram read are registered into the compute stage, and
//   its result then into the output register. a new request is not taken while one
//   is in the compute stage: the identifier ram read and its read-modify-write back are not overlapped across requests.
//   reset: aresetn (synchronous, active low) clears the stream totals and starts
//   a clearing pass over the identifier ram, one entry per cycle, 16384 entries;
//   s_tready stays low until the pass is done.
//   stall: a held result waits in the output register; the next request is taken
//   as soon as the output register is free or being drained in that cycle.
module ts_continuity_checker
    import tscc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // packet_id, cont_count, tei_flag, null_flag, pcr_flag, disc_flag, payload_flag, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // stream_sel
    input  logic [SEL_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cc_status, stream_packets, stream_tei_errors, stream_nulls, stream_pcrs,
    // stream_dups, stream_cc_errors, pid_packets, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    pid_entry_t mem [TABLE_DEPTH];
    pid_entry_t rd_data_reg;

    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    hdr_t             p1_hdr_reg;

    logic [CNT_W-1:0] pkt_tot_reg  [STREAM_COUNT];
    logic [CNT_W-1:0] tei_tot_reg  [STREAM_COUNT];
    logic [CNT_W-1:0] null_tot_reg [STREAM_COUNT];
    logic [CNT_W-1:0] pcr_tot_reg  [STREAM_COUNT];
    logic [CNT_W-1:0] dup_tot_reg  [STREAM_COUNT];
    logic [CNT_W-1:0] err_tot_reg  [STREAM_COUNT];

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    hdr_t             s_hdr;
    logic             s_accept;
    logic [SEL_W-1:0] p1_sel;
    logic             do_check;
    logic [CC_W-1:0]  prev_plus;
    cc_status_t       status;
    pid_entry_t       wr_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pid_entry_t       wr_data;
    logic [CNT_W-1:0] pkt_next, tei_next, null_next, pcr_next, dup_next, err_next;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    // tdata carries packet_id in the lowest bits, the struct holds it in the highest
    assign s_hdr    = {s_tdata[PID_W-1:0], s_tdata[PID_W +: CC_W],
                       s_tdata[PID_W+CC_W], s_tdata[PID_W+CC_W+1],
                       s_tdata[PID_W+CC_W+2], s_tdata[PID_W+CC_W+3],
                       s_tdata[PID_W+CC_W+4]};
    assign s_tready = !clr_active_reg && !p1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign p1_sel   = p1_idx_reg[IDX_W-1 -: SEL_W];

    always_comb begin
        do_check  = !(p1_hdr_reg.null_flag || p1_hdr_reg.tei_flag || p1_hdr_reg.disc_flag)
                    && rd_data_reg.seen;
        prev_plus = rd_data_reg.last_cc + 1'b1;
        status    = CC_UNCHECKED;
        if (do_check) begin
            if (p1_hdr_reg.payload_flag) begin
                if (p1_hdr_reg.cont_count == rd_data_reg.last_cc) begin
                    status = CC_DUPLICATE;
                end else if (p1_hdr_reg.cont_count != prev_plus) begin
                    status = CC_ERROR;
                end else begin
                    status = CC_IN_ORDER;
                end
            end else if (p1_hdr_reg.cont_count != rd_data_reg.last_cc) begin
                status = CC_ERROR;
            end else begin
                status = CC_IN_ORDER;
            end
        end

        pkt_next  = sat_inc(pkt_tot_reg[p1_sel], 1'b1);
        tei_next  = sat_inc(tei_tot_reg[p1_sel], p1_hdr_reg.tei_flag);
        null_next = sat_inc(null_tot_reg[p1_sel], p1_hdr_reg.null_flag);
        pcr_next  = sat_inc(pcr_tot_reg[p1_sel], p1_hdr_reg.pcr_flag);
        dup_next  = sat_inc(dup_tot_reg[p1_sel], status == CC_DUPLICATE);
        err_next  = sat_inc(err_tot_reg[p1_sel], status == CC_ERROR);

        wr_entry.last_cc   = p1_hdr_reg.cont_count;
        wr_entry.seen      = 1'b1;
        wr_entry.pid_count = sat_inc(rd_data_reg.pid_count, 1'b1);

        m_tdata_next = '0;
        m_tdata_next[OUT_BITS-1:0] = {wr_entry.pid_count[OUT_W-1:0], err_next[OUT_W-1:0],
                                      dup_next[OUT_W-1:0], pcr_next[OUT_W-1:0],
                                      null_next[OUT_W-1:0], tei_next[OUT_W-1:0],
                                      pkt_next[OUT_W-1:0], status};

        // clearing pass and request write-back never overlap
        wr_en   = clr_active_reg || p1_valid_reg;
        wr_addr = clr_active_reg ? clr_addr_reg : p1_idx_reg;
        wr_data = clr_active_reg ? '0 : wr_entry;
    end

    // identifier ram: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s_accept) begin
            rd_data_reg <= mem[{s_tuser, s_hdr.packet_id}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < STREAM_COUNT; i++) begin
                pkt_tot_reg[i]  <= '0;
                tei_tot_reg[i]  <= '0;
                null_tot_reg[i] <= '0;
                pcr_tot_reg[i]  <= '0;
                dup_tot_reg[i]  <= '0;
                err_tot_reg[i]  <= '0;
            end
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            p1_valid_reg <= s_accept;
            if (s_accept) begin
                p1_idx_reg <= {s_tuser, s_hdr.packet_id};
                p1_hdr_reg <= s_hdr;
            end
            if (p1_valid_reg) begin
                pkt_tot_reg[p1_sel]  <= pkt_next;
                tei_tot_reg[p1_sel]  <= tei_next;
                null_tot_reg[p1_sel] <= null_next;
                pcr_tot_reg[p1_sel]  <= pcr_next;
                dup_tot_reg[p1_sel]  <= dup_next;
                err_tot_reg[p1_sel]  <= err_next;
                m_tvalid_reg         <= 1'b1;
                m_tdata_reg          <= m_tdata_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> p1_valid_reg)
        else $error("accepted request did not reach the compute stage");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |=> m_tvalid)
        else $error("compute stage did not load a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> !$past(m_tvalid && !m_tready))
        else $error("result loaded over a stalled result");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !p1_valid_reg && !m_tvalid)
        else $error("request activity during the clearing pass");
`endif

endmodule

@@ test/tb_ts_continuity_checker.sv @@
// self-checking testbench for ts_continuity_checker: directed headers, then random streams
// checked against an in-bench continuity predictor; depends on tscc_pkg and the rtl top
module tb_ts_continuity_checker;
    import tscc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // declared msb first so that cc_status sits in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [OUT_W-1:0] pid_packets;
        logic [OUT_W-1:0] stream_cc_errors;
        logic [OUT_W-1:0] stream_dups;
        logic [OUT_W-1:0] stream_pcrs;
        logic [OUT_W-1:0] stream_nulls;
        logic [OUT_W-1:0] stream_tei_errors;
        logic [OUT_W-1:0] stream_packets;
        cc_status_t       cc_status;
    } cc_result_t;

    typedef struct {
        logic            sel;
        hdr_t            h;
        bit              typed;
        cc_status_t      status;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // packet_id, cont_count, tei_flag, null_flag, pcr_flag, disc_flag, payload_flag, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // stream_sel
    logic [SEL_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // cc_status, stream_packets, stream_tei_errors, stream_nulls, stream_pcrs,
    // stream_dups, stream_cc_errors, pid_packets, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    ts_continuity_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state, per stream and identifier
    logic [CC_W-1:0]  last_cc_mem  [TABLE_DEPTH];
    bit               seen_mem     [TABLE_DEPTH];
    logic [CNT_W-1:0] pid_cnt_mem  [TABLE_DEPTH];
    logic [CNT_W-1:0] pkt_total    [STREAM_COUNT];
    logic [CNT_W-1:0] tei_total    [STREAM_COUNT];
    logic [CNT_W-1:0] null_total   [STREAM_COUNT];
    logic [CNT_W-1:0] pcr_total    [STREAM_COUNT];
    logic [CNT_W-1:0] dup_total    [STREAM_COUNT];
    logic [CNT_W-1:0] ccerr_total  [STREAM_COUNT];

    cc_result_t expected_results [$];
    dir_row_t   dir_rows [$];
    cc_result_t got_res;
    cc_result_t want_res;

    logic [PID_W-1:0] pid_pool [8] = '{13'h0000, 13'h0001, 13'h0011, 13'h0100,
                                       13'h1FFF, 13'h0ABC, 13'h1000, 13'h0042};

    int  cycle_count     = 0;
    int  mismatches      = 0;
    int  results_checked = 0;
    int  headers_sent    = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    int  send_idle_pct   = 0;
    int  recv_stall_pct  = 0;
    int  hold_left       = 0;
    bit  hold_done       = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // continuity check and saturating totals for one accepted header
    function automatic cc_result_t predict_cc_check(input logic sel, input hdr_t h);
        logic [IDX_W-1:0] idx;
        logic [CC_W-1:0]  prev;
        logic [CC_W-1:0]  next_cc;
        cc_result_t       r;
        idx = {sel, h.packet_id};
        pkt_total[sel]   = bump(pkt_total[sel]);
        pid_cnt_mem[idx] = bump(pid_cnt_mem[idx]);
        if (h.tei_flag)  tei_total[sel]  = bump(tei_total[sel]);
        if (h.null_flag) null_total[sel] = bump(null_total[sel]);
        if (h.pcr_flag)  pcr_total[sel]  = bump(pcr_total[sel]);
        r.cc_status = CC_UNCHECKED;
        if (!(h.null_flag || h.tei_flag || h.disc_flag) && seen_mem[idx]) begin
            prev    = last_cc_mem[idx];
            next_cc = prev + 1'b1;
            if (h.payload_flag && h.cont_count == prev) begin
                dup_total[sel] = bump(dup_total[sel]);
                r.cc_status = CC_DUPLICATE;
            end else if (h.cont_count != (h.payload_flag ? next_cc : prev)) begin
                ccerr_total[sel] = bump(ccerr_total[sel]);
                r.cc_status = CC_ERROR;
            end else begin
                r.cc_status = CC_IN_ORDER;
            end
        end
        last_cc_mem[idx] = h.cont_count;
        seen_mem[idx]    = 1'b1;
        r.stream_packets    = pkt_total[sel];
        r.stream_tei_errors = tei_total[sel];
        r.stream_nulls      = null_total[sel];
        r.stream_pcrs       = pcr_total[sel];
        r.stream_dups       = dup_total[sel];
        r.stream_cc_errors  = ccerr_total[sel];
        r.pid_packets       = pid_cnt_mem[idx];
        return r;
    endfunction

    task automatic put_row(input logic sel, input logic [PID_W-1:0] pid,
                           input logic [CC_W-1:0] cc, input logic tei, input logic nul,
                           input logic pcr, input logic disc, input logic pay,
                           input bit typed, input cc_status_t status);
        dir_row_t row;
        row.sel    = sel;
        row.h      = '{pid, cc, tei, nul, pcr, disc, pay};
        row.typed  = typed;
        row.status = status;
        dir_rows.push_back(row);
    endtask

    // one request on s_: optional idle gap, then hold until accepted
    task automatic send_header(input logic sel, input hdr_t h, input bit typed,
                               input cc_status_t typed_status);
        cc_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sel;
        s_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, h.payload_flag, h.disc_flag, h.pcr_flag,
                     h.null_flag, h.tei_flag, h.cont_count, h.packet_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_cc_check(sel, h);
        if (typed) r.cc_status = typed_status;
        expected_results.push_back(r);
        headers_sent++;
        @(negedge aclk);
    endtask

    // mostly well-formed continuity on a small pid pool, some noise and broken counters
    task automatic pick_header(output logic sel, output hdr_t h);
        int               r;
        logic [31:0]      rnd;
        logic [IDX_W-1:0] idx;
        r   = $urandom_range(99);
        sel = 1'($urandom_range(1));
        if (r < 10) begin
            rnd = $urandom;
            h   = rnd[IN_BITS-1:0];
        end else begin
            h.packet_id    = pid_pool[$urandom_range(7)];
            h.tei_flag     = ($urandom_range(19) == 0);
            h.null_flag    = ($urandom_range(19) == 0);
            h.disc_flag    = ($urandom_range(19) == 0);
            h.pcr_flag     = ($urandom_range(4) == 0);
            h.payload_flag = ($urandom_range(7) != 0);
            idx = {sel, h.packet_id};
            if (!seen_mem[idx] || r < 18) begin
                h.cont_count = CC_W'($urandom_range(15));
            end else if (r < 26) begin
                h.cont_count   = last_cc_mem[idx];
                h.payload_flag = 1'b1;
            end else begin
                h.cont_count = h.payload_flag ? last_cc_mem[idx] + 1'b1 : last_cc_mem[idx];
            end
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results_checked, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata[OUT_BITS-1:0];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with no request outstanding: status %0d", got_res.cc_status);
            end else begin
                want_res = expected_results.pop_front();
                results_checked++;
                status_seen[want_res.cc_status]++;
                check_field("cc_status", OUT_W'(want_res.cc_status), OUT_W'(got_res.cc_status));
                check_field("stream_packets", want_res.stream_packets, got_res.stream_packets);
                check_field("stream_tei_errors", want_res.stream_tei_errors,
                            got_res.stream_tei_errors);
                check_field("stream_nulls", want_res.stream_nulls, got_res.stream_nulls);
                check_field("stream_pcrs", want_res.stream_pcrs, got_res.stream_pcrs);
                check_field("stream_dups", want_res.stream_dups, got_res.stream_dups);
                check_field("stream_cc_errors", want_res.stream_cc_errors,
                            got_res.stream_cc_errors);
                check_field("pid_packets", want_res.pid_packets, got_res.pid_packets);
            end
        end
    end

    initial m_tready = 1'b0;

    // receiver: random stalls per phase, plus one long hold-off to back up the input
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && results_checked >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int   i;
        int   phase;
        logic sel;
        hdr_t h;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            last_cc_mem[i] = '0;
            seen_mem[i]    = 1'b0;
            pid_cnt_mem[i] = '0;
        end
        for (i = 0; i < STREAM_COUNT; i++) begin
            pkt_total[i]   = '0;
            tei_total[i]   = '0;
            null_total[i]  = '0;
            pcr_total[i]   = '0;
            dup_total[i]   = '0;
            ccerr_total[i] = '0;
        end

        //      sel  pid       cc     tei  nul  pcr  dsc  pay  typed status
        put_row(1'b0, 13'h0000, 4'd0,  0,   0,   0,   0,   1,   1, CC_UNCHECKED);
        put_row(1'b0, 13'h0000, 4'd1,  0,   0,   0,   0,   1,   0, CC_UNCHECKED);
        put_row(1'b0, 13'h0000, 4'd1,  0,   0,   0,   0,   1,   1, CC_DUPLICATE);
        put_row(1'b0, 13'h0000, 4'd1,  0,   0,   0,   0,   0,   0, CC_UNCHECKED);
        put_row(1'b0, 13'h0000, 4'd3,  0,   0,   0,   0,   0,   1, CC_ERROR);
        put_row(1'b0, 13'h0000, 4'd5,  0,   0,   0,   0,   1,   1, CC_ERROR);
        put_row(1'b0, 13'h1FFF, 4'd15, 0,   0,   0,   0,   1,   1, CC_UNCHECKED);
        // counter wraps from 15 to 0
        put_row(1'b0, 13'h1FFF, 4'd0,  0,   0,   1,   0,   1,   0, CC_UNCHECKED);
        // same identifier on the other stream starts fresh
        put_row(1'b1, 13'h1FFF, 4'd15, 0,   0,   0,   0,   1,   1, CC_UNCHECKED);
        put_row(1'b1, 13'h1FFF, 4'd7,  1,   0,   0,   0,   1,   1, CC_UNCHECKED);
        put_row(1'b1, 13'h1FFF, 4'd2,  0,   0,   0,   1,   1,   1, CC_UNCHECKED);
        put_row(1'b1, 13'h1FFF, 4'd3,  0,   0,   0,   0,   1,   0, CC_UNCHECKED);
        put_row(1'b1, 13'h1FFF, 4'd9,  0,   1,   0,   0,   0,   1, CC_UNCHECKED);
        put_row(1'b1, 13'h1FFF, 4'd9,  0,   0,   0,   0,   0,   0, CC_UNCHECKED);
        put_row(1'b0, 13'h1555, 4'd10, 1,   1,   1,   1,   1,   1, CC_UNCHECKED);
        put_row(1'b0, 13'h0AAA, 4'd5,  0,   0,   0,   0,   0,   1, CC_UNCHECKED);
        put_row(1'b0, 13'h0AAA, 4'd5,  0,   0,   0,   0,   1,   1, CC_DUPLICATE);
        put_row(1'b0, 13'h0AAA, 4'd0,  0,   0,   0,   0,   1,   1, CC_ERROR);
        put_row(1'b1, 13'h0000, 4'd0,  1,   1,   1,   1,   0,   1, CC_UNCHECKED);
        put_row(1'b0, 13'h1FFF, 4'd0,  0,   0,   0,   0,   0,   0, CC_UNCHECKED);
        put_row(1'b0, 13'h1FFF, 4'd15, 0,   0,   0,   0,   1,   1, CC_ERROR);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // the first request also waits out the ram clearing pass
        foreach (dir_rows[i])
            send_header(dir_rows[i].sel, dir_rows[i].h, dir_rows[i].typed, dir_rows[i].status);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            phase = (i * 4) / RANDOM_ITEMS;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            pick_header(sel, h);
            send_header(sel, h, 1'b0, CC_UNCHECKED);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d headers (%0d directed) over four idle/stall phases, %0d results checked",
                 headers_sent, dir_rows.size(), results_checked);
        $display("status mix: unchecked %0d, in order %0d, duplicate %0d, error %0d; mismatches %0d",
                 status_seen[CC_UNCHECKED], status_seen[CC_IN_ORDER],
                 status_seen[CC_DUPLICATE], status_seen[CC_ERROR], mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
